/* rtl/knapsack_01_best_value_assert.svh */
// assertion macros shared by the knapsack checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef KNAPSACK_01_BEST_VALUE_ASSERT_SVH
`define KNAPSACK_01_BEST_VALUE_ASSERT_SVH

// same-cycle implication, held off during reset
`define KNAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("knapsack assertion failed");

// next-cycle implication, held off during reset
`define KNAP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("knapsack assertion failed");

`endif

/* rtl/knap_pkg.sv */
// constants and types of the knapsack best-value block
// no dependencies
`timescale 1ns / 1ps

package knap_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int ROW_DEPTH    = MAX_CAPACITY + 1;
  localparam int ADDR_W       = $clog2(ROW_DEPTH);
  localparam int VALUE_BITS   = 16;
  localparam int SUM_BITS     = 24;

  // field widths of the channels
  localparam int WEIGHT_W = 11;
  localparam int ITEM_VAL_W = 16;
  localparam int CAP_W    = 11;
  localparam int OUT_W    = 24;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DRAIN,
    ST_RES_RD,
    ST_RES_WAIT
  } knap_state_e;

endpackage

/* rtl/knap_if.sv */
// valid/ready channels of the knapsack block: items, results, capacity writes
// depends on knap_pkg
`timescale 1ns / 1ps

interface knap_item_if;
  logic                          valid;
  logic                          ready;
  logic [knap_pkg::WEIGHT_W-1:0]   item_weight;
  logic [knap_pkg::ITEM_VAL_W-1:0] item_value;
  logic                          last_item;

  modport source (output valid, item_weight, item_value, last_item, input ready);
  modport sink (input valid, item_weight, item_value, last_item, output ready);
endinterface

interface knap_result_if;
  logic                       valid;
  logic                       ready;
  logic [knap_pkg::OUT_W-1:0] best_value;

  modport source (output valid, best_value, input ready);
  modport sink (input valid, best_value, output ready);
endinterface

interface knap_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [knap_pkg::CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

/* rtl/knap_ram.sv */
// generic ram: one write port, two read ports with registered read data
// no dependencies
`timescale 1ns / 1ps

module knap_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/knapsack_01_best_value.sv */
// 0/1 knapsack best value: one capacity row in ram, updated by a shared add/compare unit
// depends on knap_pkg, knap_if (channel interfaces) and knap_ram
`timescale 1ns / 1ps

// Usage
//   item_i   : requests of weight, value and a last-item mark; taken only when ready is high
//   cfg_i    : capacity writes, always ready; write only while the block is idle
//   result_o : one best value after each request marked last, held until taken
// Each request of weight up to 1024 sweeps the best-value row from capacity 1024 down
// to its weight, one entry per cycle through the single ram write port; a heavier
// request sweeps nothing. A last request adds a result read, then a clearing pass
// over the row. The result is offered after the sweep, a drain step and the result
// read, later if the previous result is still waiting. Reset starts the same
// clearing pass; item_i stays not ready until it ends, while capacity writes are
// still taken. Capacity resets to 0.
// A stalled receiver holds the result register; the block then waits before its
// clearing pass until the register is free, and item_i stays not ready meanwhile.

module knapsack_01_best_value (
  input  logic               clk_i,
  input  logic               rst_ni,
  knap_item_if.sink          item_i,
  knap_cfg_if.sink           cfg_i,
  knap_result_if.source      result_o
);

  localparam int AW = knap_pkg::ADDR_W;
  localparam int SW = knap_pkg::SUM_BITS;

  knap_pkg::knap_state_e state_q, state_d;

  logic [AW-1:0]                    idx_q, idx_d;
  logic [knap_pkg::WEIGHT_W-1:0]    weight_q, weight_d;
  logic [knap_pkg::VALUE_BITS-1:0]  value_q, value_d;
  logic                             last_q, last_d;
  logic [knap_pkg::CAP_W-1:0]       cap_q;
  logic                             pend_q, pend_d;
  logic [AW-1:0]                    waddr_q, waddr_d;
  logic                             out_valid_q, out_valid_d;
  logic [knap_pkg::OUT_W-1:0]       out_value_q, out_value_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [SW-1:0] rdata_a, rdata_b;

  logic [AW-1:0] weight_addr;
  logic [AW-1:0] cap_addr;
  logic [SW:0]   sum_full;
  logic [SW-1:0] inc_val;

  assign item_i.ready   = (state_q == knap_pkg::ST_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.best_value = out_value_q;

  assign weight_addr = AW'(weight_q);
  assign cap_addr    = (cap_q > knap_pkg::CAP_W'(knap_pkg::MAX_CAPACITY)) ?
                       AW'(knap_pkg::MAX_CAPACITY) : AW'(cap_q);

  // shared add/compare unit: best[j] vs saturated best[j-w] + v
  assign sum_full = {1'b0, rdata_b} + (SW + 1)'(value_q);
  assign inc_val  = sum_full[SW] ? {SW{1'b1}} : sum_full[SW-1:0];

  knap_ram #(
    .Width (SW),
    .Depth (knap_pkg::ROW_DEPTH)
  ) u_row (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    weight_d    = weight_q;
    value_d     = value_q;
    last_d      = last_q;
    pend_d      = 1'b0;
    waddr_d     = waddr_q;
    out_value_d = out_value_q;
    out_valid_d = out_valid_q && !result_o.ready;
    raddr_a     = idx_q;
    raddr_b     = '0;
    ram_we      = 1'b0;
    ram_waddr   = waddr_q;
    ram_wdata   = (inc_val > rdata_a) ? inc_val : rdata_a;

    // write back the entry read in the previous cycle
    if (pend_q) begin
      ram_we = 1'b1;
    end

    unique case (state_q)
      knap_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
        if (idx_q == '0) begin
          state_d = knap_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q - AW'(1);
        end
      end
      knap_pkg::ST_IDLE: begin
        if (item_i.valid) begin
          weight_d = item_i.item_weight;
          value_d  = item_i.item_value[knap_pkg::VALUE_BITS-1:0];
          last_d   = item_i.last_item;
          idx_d    = AW'(knap_pkg::MAX_CAPACITY);
          if (item_i.item_weight <= knap_pkg::WEIGHT_W'(knap_pkg::MAX_CAPACITY)) begin
            state_d = knap_pkg::ST_UPDATE;
          end else if (item_i.last_item) begin
            state_d = knap_pkg::ST_RES_RD;
          end
        end
      end
      knap_pkg::ST_UPDATE: begin
        // descending walk: later reads never hit an entry already rewritten
        raddr_a = idx_q;
        raddr_b = idx_q - weight_addr;
        pend_d  = 1'b1;
        waddr_d = idx_q;
        if (idx_q == weight_addr) begin
          state_d = knap_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q - AW'(1);
        end
      end
      knap_pkg::ST_DRAIN: begin
        state_d = last_q ? knap_pkg::ST_RES_RD : knap_pkg::ST_IDLE;
      end
      knap_pkg::ST_RES_RD: begin
        raddr_a = cap_addr;
        state_d = knap_pkg::ST_RES_WAIT;
      end
      knap_pkg::ST_RES_WAIT: begin
        raddr_a = cap_addr;
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = knap_pkg::OUT_W'(rdata_a);
          idx_d       = AW'(knap_pkg::MAX_CAPACITY);
          state_d     = knap_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_d = knap_pkg::ST_CLEAR;
        idx_d   = AW'(knap_pkg::MAX_CAPACITY);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= knap_pkg::ST_CLEAR;
      idx_q       <= AW'(knap_pkg::MAX_CAPACITY);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q    <= weight_d;
    value_q     <= value_d;
    waddr_q     <= waddr_d;
    out_value_q <= out_value_d;
  end

endmodule

/* rtl/knap_sva.sv */
// port-level checker for the knapsack block, bound to the top level
// depends on knapsack_01_best_value_assert.svh and knap_pkg
`timescale 1ns / 1ps
`include "knapsack_01_best_value_assert.svh"

module knap_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          item_valid_i,
  input logic                          item_ready_i,
  input logic [knap_pkg::WEIGHT_W-1:0] item_weight_i,
  input logic                          result_valid_i,
  input logic                          result_ready_i,
  input logic [knap_pkg::OUT_W-1:0]    best_value_i
);

  // a stalled result stays offered
  `KNAP_ASSERT_NXT(a_result_hold, result_valid_i && !result_ready_i, result_valid_i)

  // and keeps its value
  `KNAP_ASSERT_NXT(a_result_stable, result_valid_i && !result_ready_i, $stable(best_value_i))

  // item_i is not ready in the cycle after a request that fits the row is taken
  `KNAP_ASSERT_NXT(a_busy_after_request, item_valid_i && item_ready_i && (item_weight_i <= knap_pkg::WEIGHT_W'(knap_pkg::MAX_CAPACITY)), !item_ready_i)

  // a new result is only raised while the row is being cleared
  `KNAP_ASSERT_IMP(a_result_while_busy, $rose(result_valid_i), !item_ready_i)

endmodule

bind knapsack_01_best_value knap_sva u_knap_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .item_weight_i  (item_i.item_weight),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .best_value_i   (result_o.best_value)
);

/* tb/tb_top.sv */
// self-checking bench for the 0/1 knapsack best-value block: directed table, then random sets
// depends on knap_pkg, knap_if and knapsack_01_best_value from the rtl folder
`timescale 1ns / 1ps

module tb_top;
  import knap_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int IDLE_GAP     = 1100;   // covers the clearing pass after a result
  localparam int HOLD_CYCLES  = 3000;
  localparam int N_ROWS       = 20;

  typedef struct packed {
    logic                  set_cap;
    logic [CAP_W-1:0]      cap;
    logic [WEIGHT_W-1:0]   weight;
    logic [ITEM_VAL_W-1:0] value;
    logic                  last;
    logic                  fixed;
    logic [OUT_W-1:0]      fixed_best;
  } item_row_t;

  // set_cap, cap, weight, value, last, fixed, fixed_best
  item_row_t directed_rows [N_ROWS] = '{
    '{1'b0, 11'd0,    11'd1,    16'd7,     1'b1, 1'b1, 24'd0},
    '{1'b1, 11'd1024, 11'd1024, 16'd65535, 1'b1, 1'b1, 24'd65535},
    '{1'b0, 11'd0,    11'd2047, 16'd100,   1'b1, 1'b1, 24'd0},
    '{1'b1, 11'd2047, 11'd0,    16'd65535, 1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd2047, 16'd65535, 1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd1024, 16'd1,     1'b1, 1'b0, 24'd0},
    '{1'b1, 11'd0,    11'd0,    16'd300,   1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd0,    16'd44,    1'b1, 1'b1, 24'd344},
    '{1'b1, 11'd10,   11'd5,    16'd10,    1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd4,    16'd7,     1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd6,    16'd13,    1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd3,    16'd2,     1'b1, 1'b0, 24'd0},
    '{1'b1, 11'd1023, 11'd1024, 16'd65535, 1'b1, 1'b1, 24'd0},
    '{1'b1, 11'd1,    11'd1,    16'd65535, 1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd1,    16'd1,     1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd0,    16'd0,     1'b1, 1'b0, 24'd0},
    '{1'b1, 11'd1024, 11'd512,  16'd40000, 1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd512,  16'd40000, 1'b0, 1'b0, 24'd0},
    '{1'b0, 11'd0,    11'd513,  16'd65535, 1'b1, 1'b0, 24'd0},
    '{1'b1, 11'd1025, 11'd1,    16'd5,     1'b1, 1'b1, 24'd5}
  };

  logic clk_i;
  logic rst_ni;

  knap_item_if   item_ch ();
  knap_cfg_if    cfg_ch ();
  knap_result_if res_ch ();

  knapsack_01_best_value DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .cfg_i    (cfg_ch),
    .result_o (res_ch)
  );

  // predictor state
  logic [SUM_BITS-1:0] best_row_pred [0:MAX_CAPACITY];
  logic [CAP_W-1:0]    cap_reg;
  logic [OUT_W-1:0]    best_value_q [$];

  int  err_count;
  int  items_sent;
  int  cycle_cnt;
  bit  gaps_on;
  bit  hold_req;
  logic [OUT_W-1:0] want_best;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    err_count++;
  endtask

  // applies one request to the predicted row; returns 1 and the best value on a last mark
  function automatic bit apply_item(input logic [WEIGHT_W-1:0] weight,
                                    input logic [ITEM_VAL_W-1:0] value,
                                    input logic last,
                                    output logic [OUT_W-1:0] best);
    int wi;
    int j;
    int cap_idx;
    logic [SUM_BITS:0] sum;
    wi = weight;
    best = '0;
    if (wi <= MAX_CAPACITY) begin
      for (j = MAX_CAPACITY; j >= wi; j--) begin
        sum = {1'b0, best_row_pred[j-wi]} + (SUM_BITS+1)'(value[VALUE_BITS-1:0]);
        if (sum > {1'b0, {SUM_BITS{1'b1}}}) sum = {1'b0, {SUM_BITS{1'b1}}};
        if (sum[SUM_BITS-1:0] > best_row_pred[j]) best_row_pred[j] = sum[SUM_BITS-1:0];
      end
    end
    if (!last) return 1'b0;
    cap_idx = cap_reg;
    if (cap_idx > MAX_CAPACITY) cap_idx = MAX_CAPACITY;
    best = OUT_W'(best_row_pred[cap_idx]);
    for (j = 0; j <= MAX_CAPACITY; j++) best_row_pred[j] = '0;
    return 1'b1;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1023;
      3: return 11'd1024;
      4: return CAP_W'($urandom_range(1025, 2047));
      5: return CAP_W'($urandom_range(0, 64));
      default: return CAP_W'($urandom_range(0, 1024));
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [WEIGHT_W-1:0] weight,
                           input logic [ITEM_VAL_W-1:0] value,
                           input logic last, input logic fixed,
                           input logic [OUT_W-1:0] fixed_best);
    logic [OUT_W-1:0] best;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    item_ch.item_weight = weight;
    item_ch.item_value  = value;
    item_ch.last_item   = last;
    item_ch.valid       = 1'b1;
    do @(posedge clk_i); while (!item_ch.ready);
    if (apply_item(weight, value, last, best)) best_value_q.push_back(fixed ? fixed_best : best);
    items_sent++;
    @(negedge clk_i);
  endtask

  // capacity only changes once the block has gone quiet
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    item_ch.valid = 1'b0;
    while (best_value_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.capacity = cap;
    cfg_ch.valid    = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cap_reg = cap;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_sets);
    int s;
    int i;
    int len;
    logic [WEIGHT_W-1:0] weight;
    logic [ITEM_VAL_W-1:0] value;
    write_capacity(cap);
    for (s = 0; s < n_sets; s++) begin
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0: weight = WEIGHT_W'($urandom_range(1025, 2047));
          1: weight = '0;
          2: weight = WEIGHT_W'($urandom_range(0, 15));
          3: weight = WEIGHT_W'($urandom_range(1000, 1024));
          default: weight = WEIGHT_W'($urandom_range(0, 1024));
        endcase
        case ($urandom_range(0, 7))
          0: value = '0;
          1: value = '1;
          default: value = ITEM_VAL_W'($urandom_range(0, 65535));
        endcase
        send_item(weight, value, i == len - 1, 1'b0, '0);
      end
    end
  endtask

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req     = 1'b0;
        res_ch.ready = 1'b0;
        hold_cnt     = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk_i);
          hold_cnt++;
        end
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        res_ch.ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (best_value_q.size() == 0) begin
        report_mismatch("unexpected result, best_value", '0, res_ch.best_value);
      end else begin
        want_best = best_value_q.pop_front();
        if (res_ch.best_value !== want_best)
          report_mismatch("best_value", want_best, res_ch.best_value);
      end
    end
  end

  initial begin
    int r;
    int i;
    err_count  = 0;
    items_sent = 0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    cap_reg    = '0;
    for (r = 0; r <= MAX_CAPACITY; r++) best_row_pred[r] = '0;
    item_ch.valid       = 1'b0;
    item_ch.item_weight = '0;
    item_ch.item_value  = '0;
    item_ch.last_item   = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.capacity     = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].set_cap) write_capacity(directed_rows[r].cap);
      send_item(directed_rows[r].weight, directed_rows[r].value, directed_rows[r].last,
                directed_rows[r].fixed, directed_rows[r].fixed_best);
    end

    // receiver stalls for a long stretch while short requests keep coming
    write_capacity(11'd1024);
    hold_req = 1'b1;
    for (i = 0; i < 12; i++)
      send_item(WEIGHT_W'($urandom_range(1010, 1024)), ITEM_VAL_W'($urandom_range(0, 65535)),
                1'b1, 1'b0, '0);

    while (items_sent < 300) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      run_phase(pick_capacity(), $urandom_range(2, 6));
    end

    // one long set of light, valuable requests drives the sum into saturation
    gaps_on = 1'b1;
    write_capacity(11'd1024);
    for (i = 0; i < 262; i++)
      send_item(WEIGHT_W'($urandom_range(0, 3)), ITEM_VAL_W'($urandom_range(65000, 65535)),
                i == 261, 1'b0, '0);

    while (items_sent < 560) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      run_phase(pick_capacity(), $urandom_range(2, 6));
    end

    gaps_on = 1'b0;
    run_phase(pick_capacity(), 4);

    item_ch.valid = 1'b0;
    while (best_value_q.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
